/* hw/rtl/acr_pkg.sv */
package acr_pkg;

  localparam int unsigned ID_WIDTH     = 16;
  localparam int unsigned MARGIN_WIDTH = 8;
  localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = 8'd1;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_CHECK = 1'b1
  } acr_cmd_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } acr_axis_e;

  typedef struct packed {
    logic      hit;
    acr_axis_e axis;
  } acr_res_t;

endpackage

/* hw/rtl/aabb_collision_resolve_top.sv */
// Box collision resolver. A word with tuser 0 loads the moving box (position, size, velocity,
// id) and clears the supported flag; a word with tuser 1 checks one obstacle box against it and
// gives at most one result word: the push axis in tuser and the signed, saturated push with the
// supported flag in tdata. One word is taken per cycle, with no gaps while s_axis_tready is high;
// a result leaves through the input register, resolve logic and result register, and a stalled
// result register holds back the input through s_axis_tready. Margin is written through cfg_we_i
// by the user only while the stream is idle (not enforced by the block) and resets to 1.
module aabb_collision_resolve_top #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [acr_pkg::MARGIN_WIDTH-1:0]            cfg_wdata_i,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // pos_x, pos_y, pos_z, size_x, size_y, size_z, vel_x, vel_y, vel_z, body_id
  input  logic [((9*COORD_WIDTH+10+7)/8)*8-1:0]       s_axis_tdata,
  // cmd
  input  logic [0:0]                                  s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // push_amount, supported_seen
  output logic [((COORD_WIDTH+3+7)/8)*8-1:0]          m_axis_tdata,
  // push_axis
  output logic [1:0]                                  m_axis_tuser
);
  import acr_pkg::*;

  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned SW      = COORD_WIDTH - 2;
  localparam int unsigned IN_BITS = 9*COORD_WIDTH + 10;
  localparam int unsigned OUT_W   = ((COORD_WIDTH+3+7)/8)*8;

  logic               s1_valid_d, s1_valid_q;
  logic [IN_BITS-1:0] s1_data_q;
  acr_cmd_e           s1_cmd_q;
  logic               adv, fire, load, hit;
  logic               out_valid_d, out_valid_q;
  acr_axis_e          out_axis_q;
  logic signed [CW+1:0] out_amount_q;
  logic               out_sup_q;

  logic signed [CW-1:0] in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z;
  logic [SW-1:0]        in_size_x, in_size_y, in_size_z;
  logic [ID_WIDTH-1:0]  in_id;

  logic signed [CW-1:0] mov_pos_x, mov_pos_y, mov_pos_z, mov_vel_x, mov_vel_y, mov_vel_z;
  logic [SW-1:0]        mov_size_x, mov_size_y, mov_size_z;
  logic [ID_WIDTH-1:0]  mov_id;
  logic [MARGIN_WIDTH-1:0] margin;
  logic                 support;
  acr_res_t             res;
  logic signed [CW+1:0] push_amount;

  assign adv           = !out_valid_q || m_axis_tready;
  assign fire          = s1_valid_q && adv;
  assign s_axis_tready = !s1_valid_q || adv;
  assign load          = fire && (s1_cmd_q == CMD_LOAD);
  assign hit           = fire && (s1_cmd_q == CMD_CHECK) && res.hit;

  assign s1_valid_d = s_axis_tready ? s_axis_tvalid : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_data_q <= s_axis_tdata[IN_BITS-1:0];
      s1_cmd_q  <= acr_cmd_e'(s_axis_tuser[0]);
    end
  end

  assign in_pos_x  = s1_data_q[CW-1:0];
  assign in_pos_y  = s1_data_q[2*CW-1:CW];
  assign in_pos_z  = s1_data_q[3*CW-1:2*CW];
  assign in_size_x = s1_data_q[3*CW+SW-1:3*CW];
  assign in_size_y = s1_data_q[3*CW+2*SW-1:3*CW+SW];
  assign in_size_z = s1_data_q[3*CW+3*SW-1:3*CW+2*SW];
  assign in_vel_x  = s1_data_q[4*CW+3*SW-1:3*CW+3*SW];
  assign in_vel_y  = s1_data_q[5*CW+3*SW-1:4*CW+3*SW];
  assign in_vel_z  = s1_data_q[6*CW+3*SW-1:5*CW+3*SW];
  assign in_id     = s1_data_q[IN_BITS-1:6*CW+3*SW];

  acr_box_state #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .hit_i       (hit),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pos_x_i     (in_pos_x),
    .pos_y_i     (in_pos_y),
    .pos_z_i     (in_pos_z),
    .size_x_i    (in_size_x),
    .size_y_i    (in_size_y),
    .size_z_i    (in_size_z),
    .vel_x_i     (in_vel_x),
    .vel_y_i     (in_vel_y),
    .vel_z_i     (in_vel_z),
    .body_id_i   (in_id),
    .mov_pos_x_o (mov_pos_x),
    .mov_pos_y_o (mov_pos_y),
    .mov_pos_z_o (mov_pos_z),
    .mov_size_x_o(mov_size_x),
    .mov_size_y_o(mov_size_y),
    .mov_size_z_o(mov_size_z),
    .mov_vel_x_o (mov_vel_x),
    .mov_vel_y_o (mov_vel_y),
    .mov_vel_z_o (mov_vel_z),
    .mov_id_o    (mov_id),
    .margin_o    (margin),
    .support_o   (support)
  );

  acr_resolve #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_resolve (
    .mov_pos_x_i  (mov_pos_x),
    .mov_pos_y_i  (mov_pos_y),
    .mov_pos_z_i  (mov_pos_z),
    .mov_size_x_i (mov_size_x),
    .mov_size_y_i (mov_size_y),
    .mov_size_z_i (mov_size_z),
    .mov_vel_x_i  (mov_vel_x),
    .mov_vel_y_i  (mov_vel_y),
    .mov_vel_z_i  (mov_vel_z),
    .mov_id_i     (mov_id),
    .pos_x_i      (in_pos_x),
    .pos_y_i      (in_pos_y),
    .pos_z_i      (in_pos_z),
    .size_x_i     (in_size_x),
    .size_y_i     (in_size_y),
    .size_z_i     (in_size_z),
    .body_id_i    (in_id),
    .margin_i     (margin),
    .res_o        (res),
    .push_amount_o(push_amount)
  );

  assign out_valid_d = adv ? hit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // flag after a hit is always set
  always_ff @(posedge clk_i) begin
    if (hit) begin
      out_axis_q   <= res.axis;
      out_amount_q <= push_amount;
      out_sup_q    <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_sup_q, out_amount_q});
  assign m_axis_tuser  = out_axis_q;

  a_result_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.hit && s1_cmd_q == CMD_LOAD) |=> !out_valid_q || $past(out_valid_q))
    else $error("load word produced a result");

  a_result_supported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && $past(hit)) |-> support && out_sup_q)
    else $error("result without supported flag");

  a_load_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> !support)
    else $error("load did not clear supported flag");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> s1_valid_q && $stable(s1_data_q))
    else $error("stalled input word lost");

endmodule

/* hw/rtl/acr_box_state.sv */
module acr_box_state #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic                                  hit_i,
  input  logic                                  cfg_we_i,
  input  logic [acr_pkg::MARGIN_WIDTH-1:0]      cfg_wdata_i,
  input  logic signed [COORD_WIDTH-1:0]         pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]         pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]         pos_z_i,
  input  logic [COORD_WIDTH-3:0]                size_x_i,
  input  logic [COORD_WIDTH-3:0]                size_y_i,
  input  logic [COORD_WIDTH-3:0]                size_z_i,
  input  logic signed [COORD_WIDTH-1:0]         vel_x_i,
  input  logic signed [COORD_WIDTH-1:0]         vel_y_i,
  input  logic signed [COORD_WIDTH-1:0]         vel_z_i,
  input  logic [acr_pkg::ID_WIDTH-1:0]          body_id_i,
  output logic signed [COORD_WIDTH-1:0]         mov_pos_x_o,
  output logic signed [COORD_WIDTH-1:0]         mov_pos_y_o,
  output logic signed [COORD_WIDTH-1:0]         mov_pos_z_o,
  output logic [COORD_WIDTH-3:0]                mov_size_x_o,
  output logic [COORD_WIDTH-3:0]                mov_size_y_o,
  output logic [COORD_WIDTH-3:0]                mov_size_z_o,
  output logic signed [COORD_WIDTH-1:0]         mov_vel_x_o,
  output logic signed [COORD_WIDTH-1:0]         mov_vel_y_o,
  output logic signed [COORD_WIDTH-1:0]         mov_vel_z_o,
  output logic [acr_pkg::ID_WIDTH-1:0]          mov_id_o,
  output logic [acr_pkg::MARGIN_WIDTH-1:0]      margin_o,
  output logic                                  support_o
);
  import acr_pkg::*;

  logic support_d, support_q;
  logic [MARGIN_WIDTH-1:0] margin_q;

  always_comb begin
    support_d = support_q;
    if (load_i) begin
      support_d = 1'b0;
    end else if (hit_i) begin
      support_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      support_q <= 1'b0;
      margin_q  <= MARGIN_RESET;
    end else begin
      support_q <= support_d;
      if (cfg_we_i) begin
        margin_q <= cfg_wdata_i;
      end
    end
  end

  // moving box resets to an all-zero box with id 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mov_pos_x_o  <= '0;
      mov_pos_y_o  <= '0;
      mov_pos_z_o  <= '0;
      mov_size_x_o <= '0;
      mov_size_y_o <= '0;
      mov_size_z_o <= '0;
      mov_vel_x_o  <= '0;
      mov_vel_y_o  <= '0;
      mov_vel_z_o  <= '0;
      mov_id_o     <= '0;
    end else if (load_i) begin
      mov_pos_x_o  <= pos_x_i;
      mov_pos_y_o  <= pos_y_i;
      mov_pos_z_o  <= pos_z_i;
      mov_size_x_o <= size_x_i;
      mov_size_y_o <= size_y_i;
      mov_size_z_o <= size_z_i;
      mov_vel_x_o  <= vel_x_i;
      mov_vel_y_o  <= vel_y_i;
      mov_vel_z_o  <= vel_z_i;
      mov_id_o     <= body_id_i;
    end
  end

  assign margin_o  = margin_q;
  assign support_o = support_q;

endmodule

/* hw/rtl/acr_resolve.sv */
module acr_resolve #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic signed [COORD_WIDTH-1:0]    mov_pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]    mov_pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]    mov_pos_z_i,
  input  logic [COORD_WIDTH-3:0]           mov_size_x_i,
  input  logic [COORD_WIDTH-3:0]           mov_size_y_i,
  input  logic [COORD_WIDTH-3:0]           mov_size_z_i,
  input  logic signed [COORD_WIDTH-1:0]    mov_vel_x_i,
  input  logic signed [COORD_WIDTH-1:0]    mov_vel_y_i,
  input  logic signed [COORD_WIDTH-1:0]    mov_vel_z_i,
  input  logic [acr_pkg::ID_WIDTH-1:0]     mov_id_i,
  input  logic signed [COORD_WIDTH-1:0]    pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]    pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]    pos_z_i,
  input  logic [COORD_WIDTH-3:0]           size_x_i,
  input  logic [COORD_WIDTH-3:0]           size_y_i,
  input  logic [COORD_WIDTH-3:0]           size_z_i,
  input  logic [acr_pkg::ID_WIDTH-1:0]     body_id_i,
  input  logic [acr_pkg::MARGIN_WIDTH-1:0] margin_i,
  output acr_pkg::acr_res_t                res_o,
  output logic signed [COORD_WIDTH+1:0]    push_amount_o
);
  import acr_pkg::*;

  // working width: every sum below stays exact
  localparam int unsigned W = COORD_WIDTH + 4;
  localparam logic signed [W-1:0] PUSH_MAX = {{(W-COORD_WIDTH-1){1'b0}}, {(COORD_WIDTH+1){1'b1}}};
  localparam logic signed [W-1:0] PUSH_MIN = ~PUSH_MAX;

  logic signed [W-1:0] mpx, mpy, mpz, msx, msy, msz, mvz;
  logic signed [W-1:0] px, py, pz, sx, sy, sz, mg;
  logic signed [W-1:0] mx_hi, my_hi, mz_hi, ox_hi, oy_hi, oz_hi, z0, z0_hi;
  logic signed [W-1:0] dxn, dxp, dyn, dyp, best, amount, amount_sat;
  logic                overlap, was_z, side_pos, vx_nz, vy_nz;
  acr_axis_e           axis;

  assign mpx = $signed({{4{mov_pos_x_i[COORD_WIDTH-1]}}, mov_pos_x_i});
  assign mpy = $signed({{4{mov_pos_y_i[COORD_WIDTH-1]}}, mov_pos_y_i});
  assign mpz = $signed({{4{mov_pos_z_i[COORD_WIDTH-1]}}, mov_pos_z_i});
  assign mvz = $signed({{4{mov_vel_z_i[COORD_WIDTH-1]}}, mov_vel_z_i});
  assign msx = $signed({6'b0, mov_size_x_i});
  assign msy = $signed({6'b0, mov_size_y_i});
  assign msz = $signed({6'b0, mov_size_z_i});
  assign px  = $signed({{4{pos_x_i[COORD_WIDTH-1]}}, pos_x_i});
  assign py  = $signed({{4{pos_y_i[COORD_WIDTH-1]}}, pos_y_i});
  assign pz  = $signed({{4{pos_z_i[COORD_WIDTH-1]}}, pos_z_i});
  assign sx  = $signed({6'b0, size_x_i});
  assign sy  = $signed({6'b0, size_y_i});
  assign sz  = $signed({6'b0, size_z_i});
  assign mg  = $signed({{(W-MARGIN_WIDTH){1'b0}}, margin_i});

  assign mx_hi = mpx + msx;
  assign my_hi = mpy + msy;
  assign mz_hi = mpz + msz;
  assign ox_hi = px + sx;
  assign oy_hi = py + sy;
  assign oz_hi = pz + sz;
  assign z0    = mpz - mvz;
  assign z0_hi = z0 + msz;

  // inclusive in x and y, strict in z
  assign overlap = (body_id_i != mov_id_i) &&
                   !(mx_hi < px) && !(mpx > ox_hi) &&
                   !(my_hi < py) && !(mpy > oy_hi) &&
                   !(mz_hi <= pz) && !(mpz >= oz_hi);
  assign was_z   = !(z0_hi <= pz) && !(z0 >= oz_hi);

  assign dxn   = mx_hi - px;
  assign dxp   = ox_hi - mpx;
  assign dyn   = my_hi - py;
  assign dyp   = oy_hi - mpy;
  assign vx_nz = (mov_vel_x_i != '0);
  assign vy_nz = (mov_vel_y_i != '0);

  always_comb begin
    best     = '0;
    axis     = AXIS_X;
    side_pos = 1'b0;
    amount   = '0;
    if (was_z) begin
      if (vx_nz) begin
        best = dxn;
        if (dxp + mg < dxn) begin
          best     = dxp;
          side_pos = 1'b1;
        end
      end
      if (vy_nz) begin
        if (!vx_nz) begin
          best = dyn;
          axis = AXIS_Y;
        end
        if (dyn + mg < best) begin
          best     = dyn;
          axis     = AXIS_Y;
          side_pos = 1'b0;
        end
        if (dyp + mg < best) begin
          best     = dyp;
          axis     = AXIS_Y;
          side_pos = 1'b1;
        end
      end
      amount = side_pos ? (best + mg) : -(best + mg);
    end else begin
      axis = AXIS_Z;
      if (mov_vel_z_i > 0) begin
        amount = pz - mz_hi;
      end else begin
        amount = oz_hi - mpz;
      end
    end
  end

  always_comb begin
    amount_sat = amount;
    if (amount > PUSH_MAX) begin
      amount_sat = PUSH_MAX;
    end else if (amount < PUSH_MIN) begin
      amount_sat = PUSH_MIN;
    end
  end

  assign res_o.hit     = overlap;
  assign res_o.axis    = axis;
  assign push_amount_o = amount_sat[COORD_WIDTH+1:0];

endmodule
